// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// clk and rst_n are taken from the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is asserted
`define FOGR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// same-cycle implication from a trigger
`define FOGR_ASSERT_IMPL(label, ante, cons, msg) \
  `FOGR_ASSERT(label, (ante) |-> (cons), msg)

`endif

// ----- rtl/fogr_pkg.sv -----
// fog ramp package: field widths, command codes, payload and control structs
// and the fixed fog curve; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fogr_pkg;

  localparam int RAMP_ENTRIES = 128;
  localparam int CURVE_POINTS = 17;
  localparam int RAMP_AW      = $clog2(RAMP_ENTRIES);
  localparam int NEAR_W       = 27;
  localparam int DEPTH_W      = 31;
  localparam int OUT_W        = 13;
  localparam int Q_W          = DEPTH_W - 4;
  localparam int Q8_W         = NEAR_W - 4;
  localparam int SHIFT_W      = 5;
  localparam int REM_W        = Q8_W + 1;
  localparam int STEP_W       = 6;
  localparam int DIVC_W       = $clog2(STEP_W);
  localparam int T_W          = 13;
  localparam int FRAC_W       = 16;
  localparam int PROD_W       = 14 + FRAC_W + 1;
  localparam int CURVE_AW     = $clog2(CURVE_POINTS);

  localparam logic [NEAR_W-1:0]  NEAR_RESET = 27'd131072;
  localparam logic [OUT_W-1:0]   ONE_Q12    = 13'd4096;
  localparam logic [SHIFT_W-1:0] SEG_SHIFT  = 5'd7;

  localparam logic [1:0] CMD_REBUILD = 2'd0;
  localparam logic [1:0] CMD_INTERP  = 2'd1;
  localparam logic [1:0] CMD_NEAREST = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic [DEPTH_W-1:0] depth;
  } fogr_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] weight;
    logic [OUT_W-1:0] fog_amount;
  } fogr_out_t;

  typedef struct packed {
    logic latch_in;
    logic log_init;
    logic log_step;
    logic div_init;
    logic div_step;
    logic fill_step;
    logic rd;
    logic mul;
    logic fin;
  } fogr_cmd_t;

  typedef struct packed {
    logic m_zero;
    logic fill_last;
  } fogr_stat_t;

  function automatic logic [7:0] fog_curve(input logic [CURVE_AW-1:0] idx);
    logic [7:0] v;
    case (idx)
      5'd0:    v = 8'h00;
      5'd1:    v = 8'h00;
      5'd2:    v = 8'h26;
      5'd3:    v = 8'h4C;
      5'd4:    v = 8'h5E;
      5'd5:    v = 8'h70;
      5'd6:    v = 8'h85;
      5'd7:    v = 8'h99;
      5'd8:    v = 8'hB0;
      5'd9:    v = 8'hBD;
      5'd10:   v = 8'hD1;
      5'd11:   v = 8'hDC;
      5'd12:   v = 8'hE6;
      5'd13:   v = 8'hF0;
      5'd14:   v = 8'hF5;
      5'd15:   v = 8'hFA;
      default: v = 8'hFF;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fog_ramp_build_and_lookup.sv -----
// lookup (interpolated or nearest): the start transfer is followed by ramp read,
//   interpolation multiply and result register, then the result strobe; an unused
//   command goes straight to the result register; a new start is taken once idle again
// rebuild: log2 count, step divide, then one ramp entry per cycle over 128, then the
//   result register and strobe; result is zero
// synchronous active-low reset clears control, near distance 131072; no output stall
`timescale 1ns / 1ps
`default_nettype none

module fog_ramp_build_and_lookup import fogr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  fogr_in_t          in_payload,
  output logic              out_strobe,
  output fogr_out_t         out_payload,
  input  logic              cfg_we,
  input  logic [NEAR_W-1:0] cfg_wdata
);

  fogr_cmd_t  cmd;
  fogr_stat_t stat;

  fogr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_payload.command),
    .stat       (stat),
    .busy       (busy),
    .cmd        (cmd)
  );

  fogr_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_payload  (in_payload),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cmd         (cmd),
    .stat        (stat),
    .out_strobe  (out_strobe),
    .out_payload (out_payload)
  );

endmodule

`default_nettype wire

// ----- rtl/fogr_ctrl.sv -----
// fog ramp controller: state machine sequencing rebuild and lookup work
// depends on fogr_pkg
`timescale 1ns / 1ps
`default_nettype none

module fogr_ctrl import fogr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_command,
  input  fogr_stat_t stat,
  output logic       busy,
  output fogr_cmd_t  cmd
);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_LOG  = 7'b0000010,
    ST_DIV  = 7'b0000100,
    ST_FILL = 7'b0001000,
    ST_RD   = 7'b0010000,
    ST_MUL  = 7'b0100000,
    ST_DONE = 7'b1000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [DIVC_W-1:0]   div_cnt_r, div_cnt_nxt;

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.latch_in = 1'b1;
          unique case (in_command) inside
            CMD_REBUILD: begin
              cmd.log_init = 1'b1;
              state_nxt    = ST_LOG;
            end
            CMD_INTERP, CMD_NEAREST: state_nxt = ST_RD;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_LOG: begin
        // one bit of the log2 count per cycle
        if (stat.m_zero) begin
          cmd.div_init = 1'b1;
          div_cnt_nxt  = '0;
          state_nxt    = ST_DIV;
        end else begin
          cmd.log_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + 1'b1;
        if (div_cnt_r == DIVC_W'(STEP_W - 1)) begin
          state_nxt = ST_FILL;
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (stat.fill_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

`default_nettype wire

// ----- rtl/fogr_dpath.sv -----
// fog ramp datapath: near distance register, log2 counter, step divider,
// ramp fill, ramp memory, lookup arithmetic and result register; uses fogr_pkg
`timescale 1ns / 1ps
`default_nettype none

module fogr_dpath import fogr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  fogr_in_t          in_payload,
  input  logic              cfg_we,
  input  logic [NEAR_W-1:0] cfg_wdata,
  input  fogr_cmd_t         cmd,
  output fogr_stat_t        stat,
  output logic              out_strobe,
  output fogr_out_t         out_payload
);

  logic [NEAR_W-1:0]  near_r;
  logic [SHIFT_W-1:0] ds_r;
  logic [1:0]         cmd_r;
  logic [Q_W-1:0]     q_r;

  // rebuild state
  logic [Q8_W-1:0]    m_r;
  logic [Q8_W-1:0]    q8_r;
  logic [Q8_W-1:0]    q8_in;
  logic [REM_W-1:0]   rem_r;
  logic [REM_W-1:0]   rem_nxt;
  logic               rem_ge;
  logic [STEP_W-1:0]  quo_r;
  logic [RAMP_AW-1:0] idx_r;
  logic [T_W-1:0]     t_r;

  // fill value
  logic [3:0]         seg;
  logic [7:0]         curve_a, curve_b;
  logic [15:0]        fill_prod;
  logic [7:0]         fill_val;

  // ramp memory
  logic [7:0]         ramp_mem [RAMP_ENTRIES];
  logic [7:0]         rd0_r, rd1_r;

  // lookup address stage
  logic [SHIFT_W-1:0] k_sh;
  logic [Q_W-1:0]     idx_full;
  logic [RAMP_AW-1:0] idx_i;
  logic [FRAC_W:0]    frac_mask;
  logic [SHIFT_W-1:0] near_lsh;
  logic [Q_W-1:0]     near_tmp;
  logic [RAMP_AW-1:0] near_idx;
  logic [RAMP_AW-1:0] addr_a, addr_b;
  logic               past_r, npast_r, last_r;
  logic [FRAC_W-1:0]  frac_r;
  logic [SHIFT_W-1:0] k_r;

  // multiply and finish
  logic signed [13:0]       lo_s, hi_s, diff_s;
  logic signed [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0]        bias;
  logic signed [PROD_W-1:0] sh_s;
  logic signed [31:0]       w_full;
  logic [OUT_W-1:0]         w_clamp;
  fogr_out_t                res;
  fogr_out_t                out_r;
  logic                     strobe_r;

  // config and depth shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= NEAR_RESET;
      ds_r   <= '0;
    end else begin
      if (cfg_we) begin
        near_r <= cfg_wdata;
      end
      if (cmd.log_init) begin
        ds_r <= '0;
      end else if (cmd.log_step) begin
        ds_r <= ds_r + 1'b1;
      end
    end
  end

  // near distance in Q8, zero taken as one
  assign q8_in = (near_r[NEAR_W-1:4] == '0) ? Q8_W'(1) : near_r[NEAR_W-1:4];

  // restoring divide: step = 2^(shift+5) / q8, always in 32..63
  assign rem_ge  = (rem_r >= {1'b0, q8_r});
  assign rem_nxt = rem_ge ? (rem_r - {1'b0, q8_r}) : rem_r;

  // ramp sample at position t, linear between two curve points
  assign seg       = t_r[11:8];
  assign curve_a   = fog_curve({1'b0, seg});
  assign curve_b   = fog_curve({1'b0, seg} + 5'd1);
  assign fill_prod = {8'd0, curve_b - curve_a} * {8'd0, t_r[7:0]};
  assign fill_val  = t_r[12] ? 8'hFF : (curve_a + fill_prod[15:8]);

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r <= in_payload.command;
      q_r   <= in_payload.depth[DEPTH_W-1:4];
    end
    if (cmd.log_init) begin
      q8_r <= q8_in;
      m_r  <= q8_in - 1'b1;
    end else if (cmd.log_step) begin
      m_r <= m_r >> 1;
    end
    if (cmd.div_init) begin
      rem_r <= REM_W'(1) << ds_r;
      idx_r <= '0;
      t_r   <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_nxt << 1;
      quo_r <= {quo_r[STEP_W-2:0], rem_ge};
    end else if (cmd.fill_step) begin
      idx_r <= idx_r + 1'b1;
      if (!t_r[12]) begin
        t_r <= t_r + T_W'(quo_r);
      end
    end
  end

  assign stat.m_zero    = (m_r == '0);
  assign stat.fill_last = (idx_r == RAMP_AW'(RAMP_ENTRIES - 1));

  // lookup addressing
  assign k_sh      = (ds_r >= SEG_SHIFT) ? (ds_r - SEG_SHIFT) : '0;
  assign idx_full  = q_r >> k_sh;
  assign idx_i     = idx_full[RAMP_AW-1:0];
  assign frac_mask = ((FRAC_W + 1)'(1) << k_sh) - 1'b1;
  assign near_lsh  = SEG_SHIFT - ds_r;
  assign near_tmp  = q_r << near_lsh;
  assign near_idx  = (ds_r >= SEG_SHIFT) ? idx_i : near_tmp[RAMP_AW-1:0];
  assign addr_a    = (cmd_r == CMD_NEAREST) ? near_idx : idx_i;
  assign addr_b    = idx_i + 1'b1;

  always_ff @(posedge clk) begin
    if (cmd.fill_step) begin
      ramp_mem[idx_r] <= fill_val;
    end
    if (cmd.rd) begin
      rd0_r <= ramp_mem[addr_a];
      rd1_r <= ramp_mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      past_r  <= ((q_r >> (k_sh + SEG_SHIFT)) != '0);
      npast_r <= ((q_r >> ds_r) != '0);
      last_r  <= (idx_i == RAMP_AW'(RAMP_ENTRIES - 1));
      frac_r  <= q_r[FRAC_W-1:0] & frac_mask[FRAC_W-1:0];
      k_r     <= k_sh;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'(diff_s) * PROD_W'($signed({1'b0, frac_r}));
    end
  end

  // the last entry interpolates toward full weight
  assign lo_s   = $signed({2'b00, rd0_r, 4'b0000});
  assign hi_s   = last_r ? $signed({1'b0, ONE_Q12}) : $signed({2'b00, rd1_r, 4'b0000});
  assign diff_s = hi_s - lo_s;

  // divide by 2^k rounding toward zero
  assign bias   = prod_r[PROD_W-1] ? ((PROD_W'(1) << k_r) - 1'b1) : '0;
  assign sh_s   = $signed(prod_r + bias) >>> k_r;
  assign w_full = $signed({20'd0, rd0_r, 4'b0000}) + 32'(sh_s);

  always_comb begin
    if (w_full < 32'sd0) begin
      w_clamp = '0;
    end else if (w_full > 32'sd4096) begin
      w_clamp = ONE_Q12;
    end else begin
      w_clamp = w_full[OUT_W-1:0];
    end
  end

  always_comb begin
    res = '0;
    unique case (cmd_r)
      CMD_INTERP: begin
        res.weight     = past_r ? ONE_Q12 : w_clamp;
        res.fog_amount = ONE_Q12 - res.weight;
      end
      CMD_NEAREST: begin
        res.weight = npast_r ? OUT_W'(8'hFF) : OUT_W'(rd0_r);
      end
      default: res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.fin;
    end
  end

  assign out_strobe  = strobe_r;
  assign out_payload = out_r;

endmodule

`default_nettype wire

// ----- rtl/fogr_checker.sv -----
// port-level checks for the fog ramp block, bound to the top level
// depends on fogr_pkg and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module fogr_checker import fogr_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input fogr_out_t out_payload
);

  `FOGR_ASSERT(a_accept_busy, (start && !busy) |=> busy, "busy not raised after transfer")
  `FOGR_ASSERT(a_strobe_single, out_strobe |=> !out_strobe, "result strobe longer than one cycle")
  `FOGR_ASSERT_IMPL(a_strobe_after_work, out_strobe, $past(busy), "result without prior work")
  `FOGR_ASSERT_IMPL(a_fog_sum, out_strobe, (out_payload.fog_amount == 13'd0) || (out_payload.weight + out_payload.fog_amount == 14'd4096), "fog amount not complement of weight")
  `FOGR_ASSERT_IMPL(a_weight_range, out_strobe, out_payload.weight <= 13'd4096, "weight above one")

endmodule

bind fog_ramp_build_and_lookup fogr_checker u_fogr_checker (.*);

`default_nettype wire

// ----- tb/tb_fog_ramp_build_and_lookup.sv -----
`timescale 1ns / 1ps
// testbench for fog_ramp_build_and_lookup: directed and random commands with a
// built-in ramp predictor and a result scoreboard; depends on fogr_pkg and the rtl

module tb_fog_ramp_build_and_lookup;
  import fogr_pkg::*;

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT = 3000;
  localparam int         MAX_GAP     = 20;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  fogr_in_t            in_payload;
  logic                out_strobe;
  fogr_out_t           out_payload;
  logic                cfg_we;
  logic [NEAR_W-1:0]   cfg_wdata;

  // predictor state
  int                  fog_knots [CURVE_POINTS] = '{
    'h00, 'h00, 'h26, 'h4C, 'h5E, 'h70, 'h85, 'h99, 'hB0,
    'hBD, 'hD1, 'hDC, 'hE6, 'hF0, 'hF5, 'hFA, 'hFF
  };
  logic [7:0]          ramp_img [RAMP_ENTRIES];
  logic [SHIFT_W-1:0]  shift_now;
  logic [NEAR_W-1:0]   near_now;

  fogr_out_t           expected_q [$];
  fogr_out_t           want;
  int                  gap_pct;
  int                  stall_cycles;
  int                  n_fail, n_results, n_configs;
  int                  n_rebuild, n_interp, n_nearest, n_unused;

  fog_ramp_build_and_lookup u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_payload (in_payload),
    .out_strobe (out_strobe),
    .out_payload(out_payload),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ramp fill: sample the curve at a step derived from the near distance
  function automatic void rebuild_ramp_img();
    longint unsigned q8, m, step, t;
    int              shift, idx, seg, span, frac, a, b, v;
    q8 = near_now >> 4;
    if (q8 == 0) q8 = 1;
    shift = 0;
    for (m = q8 - 1; m != 0; m >>= 1) shift++;
    shift_now = shift[SHIFT_W-1:0];
    step = (64'd16 << (shift_now + 1)) / q8;
    if (step == 0) step = 1;
    t = 0;
    idx = 0;
    while (t < 4096 && idx < RAMP_ENTRIES) begin
      seg = int'(t >> 8);
      if (seg == 0) begin
        span = 128;
        frac = int'(t & 64'h7F);
        if ((t & 64'h80) != 0) begin
          a = 0;
          b = fog_knots[0];
        end else begin
          a = fog_knots[0];
          b = fog_knots[1];
        end
      end else begin
        span = 256;
        frac = int'(t & 64'hFF);
        a = fog_knots[seg & 15];
        b = fog_knots[(seg & 15) + 1];
      end
      v = (a * (span - frac) + b * frac) / span;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      ramp_img[idx] = v[7:0];
      t += step;
      idx++;
    end
    for (; idx < RAMP_ENTRIES; idx++) ramp_img[idx] = 8'hFF;
  endfunction

  function automatic logic [OUT_W-1:0] interp_weight(input logic [DEPTH_W-1:0] depth);
    longint unsigned q, divisor, idx, frac;
    longint          lo, hi, w;
    q = depth >> 4;
    divisor = (64'd1 << shift_now) >> 7;
    if (divisor == 0) divisor = 1;
    idx = q / divisor;
    if (idx >= RAMP_ENTRIES) return ONE_Q12;
    frac = q % divisor;
    lo = longint'(ramp_img[idx]) * 16;
    hi = (idx == RAMP_ENTRIES - 1) ? 64'sd4096 : longint'(ramp_img[idx + 1]) * 16;
    w = lo + ((hi - lo) * longint'(frac)) / longint'(divisor);
    if (w < 0) w = 0;
    if (w > 4096) w = 4096;
    return w[OUT_W-1:0];
  endfunction

  function automatic logic [OUT_W-1:0] nearest_byte(input logic [DEPTH_W-1:0] depth);
    longint unsigned q;
    q = depth >> 4;
    if (q >= (64'd1 << shift_now)) return 13'd255;
    return {5'd0, ramp_img[((q << 7) >> shift_now) & (RAMP_ENTRIES - 1)]};
  endfunction

  // updates the predictor for one accepted command and returns its result
  function automatic fogr_out_t apply_command(input fogr_in_t item);
    fogr_out_t res;
    res = '0;
    case (item.command)
      CMD_REBUILD: begin
        rebuild_ramp_img();
        n_rebuild++;
      end
      CMD_INTERP: begin
        res.weight = interp_weight(item.depth);
        res.fog_amount = ONE_Q12 - res.weight;
        n_interp++;
      end
      CMD_NEAREST: begin
        res.weight = nearest_byte(item.depth);
        n_nearest++;
      end
      default: n_unused++;
    endcase
    return res;
  endfunction

  task automatic send_command(input logic [1:0] cmd, input logic [DEPTH_W-1:0] depth);
    fogr_in_t item;
    int       gap;
    item.command = cmd;
    item.depth = depth;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_payload <= item;
    do @(posedge clk); while (busy);
    expected_q.push_back(apply_command(item));
  endtask

  // near distance only changes once every result is back and the block is idle
  task automatic write_near(input logic [NEAR_W-1:0] value);
    start <= 1'b0;
    while (expected_q.size() != 0 || busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    near_now = value;
    n_configs++;
  endtask

  function automatic logic [NEAR_W-1:0] pick_near();
    int k;
    case ($urandom_range(5))
      0: begin
        case ($urandom_range(4))
          0:       return 27'd0;
          1:       return 27'd15;
          2:       return 27'd16;
          3:       return 27'd1040;
          default: return {NEAR_W{1'b1}};
        endcase
      end
      1: return 27'd1 << $urandom_range(4, 26);
      2: begin
        k = $urandom_range(0, 22);
        return 27'((((64'd1 << k) + 1) << 4) | $urandom_range(0, 15));
      end
      3: return 27'($urandom);
      default: return 27'($urandom >> $urandom_range(5, 31));
    endcase
  endfunction

  // mostly depths inside the ramp, some around its end and some anywhere
  function automatic logic [DEPTH_W-1:0] pick_depth();
    longint unsigned span_end;
    int              sel;
    span_end = 64'd16 << shift_now;
    sel = $urandom_range(99);
    if (sel < 60) return 31'($urandom_range(0, int'(span_end - 1)));
    if (sel < 72) return 31'(span_end - 2 + $urandom_range(0, 3));
    if (sel < 86) return 31'($urandom);
    return 31'($urandom >> $urandom_range(0, 31));
  endfunction

  task automatic test_default_ramp();
    logic [DEPTH_W-1:0] end_depth;
    send_command(CMD_REBUILD, '0);
    end_depth = 31'(64'd16 << shift_now);
    send_command(CMD_INTERP, '0);
    send_command(CMD_INTERP, end_depth - 31'd1);
    send_command(CMD_INTERP, end_depth);
    send_command(CMD_INTERP, end_depth >> 1);
    send_command(CMD_INTERP, {DEPTH_W{1'b1}});
    send_command(CMD_NEAREST, '0);
    send_command(CMD_NEAREST, end_depth - 31'd16);
    send_command(CMD_NEAREST, end_depth);
    send_command(CMD_NEAREST, {DEPTH_W{1'b1}});
    send_command(CMD_UNUSED, {DEPTH_W{1'b1}});
  endtask

  // near distance zero, below 16, 1040 and the largest
  task automatic test_near_extremes();
    logic [NEAR_W-1:0]  corner [4];
    logic [DEPTH_W-1:0] end_depth;
    corner = '{27'd0, 27'd15, 27'd1040, {NEAR_W{1'b1}}};
    foreach (corner[i]) begin
      write_near(corner[i]);
      send_command(CMD_REBUILD, 31'($urandom));
      end_depth = 31'(64'd16 << shift_now);
      send_command(CMD_INTERP, end_depth - 31'd1);
      send_command(CMD_NEAREST, end_depth);
    end
  endtask

  task automatic test_random_traffic(input int pct, input int n_items);
    int         sent, burst, sel;
    logic [1:0] cmd;
    gap_pct = pct;
    sent = 0;
    while (sent < n_items) begin
      write_near(pick_near());
      send_command(CMD_REBUILD, 31'($urandom));
      sent++;
      burst = $urandom_range(8, 30);
      repeat (burst) begin
        sel = $urandom_range(99);
        if (sel < 46)      cmd = CMD_INTERP;
        else if (sel < 88) cmd = CMD_NEAREST;
        else if (sel < 94) cmd = CMD_REBUILD;
        else               cmd = CMD_UNUSED;
        send_command(cmd, pick_depth());
        sent++;
      end
    end
  endtask

  // scoreboard: every strobe is one result transfer
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      n_results++;
      if (expected_q.size() == 0) begin
        n_fail++;
        $error("unexpected result: weight %0d fog_amount %0d",
               out_payload.weight, out_payload.fog_amount);
      end else begin
        want = expected_q.pop_front();
        if (out_payload.weight !== want.weight) begin
          n_fail++;
          $error("weight: expected %0d, got %0d", want.weight, out_payload.weight);
        end
        if (out_payload.fog_amount !== want.fog_amount) begin
          n_fail++;
          $error("fog_amount: expected %0d, got %0d", want.fog_amount,
                 out_payload.fog_amount);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("fog_ramp_build_and_lookup: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_payload = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    stall_cycles = 0;
    n_fail = 0;
    n_results = 0;
    n_configs = 0;
    n_rebuild = 0;
    n_interp = 0;
    n_nearest = 0;
    n_unused = 0;
    near_now = NEAR_RESET;
    shift_now = '0;
    foreach (ramp_img[i]) ramp_img[i] = 8'h00;
    gap_pct = 6;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_default_ramp();
    test_near_extremes();
    test_random_traffic(6, 168);
    test_random_traffic(62, 168);
    test_random_traffic(0, 168);

    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("covered %0d rebuilds, %0d interpolated, %0d nearest, %0d unused commands",
             n_rebuild, n_interp, n_nearest, n_unused);
    $display("over %0d near-distance writes; %0d results checked, %0d failures",
             n_configs, n_results, n_fail);
    if (n_fail == 0) begin
      $display("fog_ramp_build_and_lookup: match");
    end else begin
      $display("fog_ramp_build_and_lookup: mismatch");
    end
    $finish;
  end

endmodule

// ----- fog_ramp_build_and_lookup.f -----
+incdir+rtl
rtl/fogr_pkg.sv
rtl/fogr_ctrl.sv
rtl/fogr_dpath.sv
rtl/fog_ramp_build_and_lookup.sv
rtl/fogr_checker.sv
tb/tb_fog_ramp_build_and_lookup.sv
